@@ design/vsfi_pkg.sv @@
// Package: constants, payload types and arithmetic helpers for vertex skinning.
package vsfi_pkg;

    localparam int NUM_BONES  = 64;
    localparam int MAT_ELEMS  = 16;
    localparam int BONE_W     = 6;
    localparam int SLOT_W     = 4;
    localparam int ADDR_W     = BONE_W + SLOT_W;
    localparam int PAL_DEPTH  = NUM_BONES * MAT_ELEMS;
    localparam int DATA_W     = 32;
    localparam int IDX_W      = 8;
    localparam int WGT_W      = 16;
    localparam int PROD_W     = 64;
    localparam int ROW_W      = 50;
    localparam int TERM_W     = 66;
    localparam int ACC_W      = 68;
    localparam int NUM_INF    = 4;
    localparam int TDATA_IN_W  = 240;
    localparam int TDATA_OUT_W = 128;
    // Registered stages ahead of the output register: read, products, row sums, weighting.
    localparam int PIPE_STAGES = 4;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_SKIN = 1'b1;

    typedef logic signed [DATA_W-1:0] q16_t;
    typedef logic [ADDR_W-1:0]        addr_t;

    function automatic q16_t sat32(input logic signed [ACC_W-1:0] x);
        q16_t r;
        if (x > $signed({{(ACC_W-DATA_W){1'b0}}, 1'b0, {(DATA_W-1){1'b1}}}))
        begin
            r = {1'b0, {(DATA_W-1){1'b1}}};
        end
        else if (x < $signed({{(ACC_W-DATA_W){1'b1}}, 1'b1, {(DATA_W-1){1'b0}}}))
        begin
            r = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            r = x[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ design/vsfi_ram.sv @@
// Generic single-port-write, one-port registered-read RAM.
module vsfi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/vsfi_lane.sv @@
// One influence lane: matrix-vector row sums and weight scaling over three stages.
module vsfi_lane (
    input  logic                              clk,
    input  logic                              adv,
    input  logic [vsfi_pkg::DATA_W-1:0]       m [16],
    input  logic signed [vsfi_pkg::DATA_W-1:0] px,
    input  logic signed [vsfi_pkg::DATA_W-1:0] py,
    input  logic signed [vsfi_pkg::DATA_W-1:0] pz,
    input  logic [vsfi_pkg::WGT_W-1:0]        wgt,
    input  logic                              use_inf,
    output logic signed [vsfi_pkg::TERM_W-1:0] term [4]
);
    // Stage A: 16 products, each floored by 2^16.
    logic signed [vsfi_pkg::PROD_W-17:0] prod_reg [16];
    logic [vsfi_pkg::WGT_W-1:0] wa_reg;
    logic use_a_reg;
    // Stage B: row sums.
    logic signed [vsfi_pkg::ROW_W-1:0] row_reg [4];
    logic [vsfi_pkg::WGT_W-1:0] wb_reg;
    logic use_b_reg;
    // Stage C: weighted terms.
    logic signed [vsfi_pkg::TERM_W-1:0] term_reg [4];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 4; c++)
            begin
                for (int r = 0; r < 4; r++)
                begin
                    logic signed [vsfi_pkg::PROD_W-1:0] p;
                    case (c)
                        0: p = $signed(m[c*4+r]) * px;
                        1: p = $signed(m[c*4+r]) * py;
                        2: p = $signed(m[c*4+r]) * pz;
                        default: p = {{16{m[c*4+r][31]}}, m[c*4+r], 16'h0000};
                    endcase
                    prod_reg[c*4+r] <= p[vsfi_pkg::PROD_W-1:16];
                end
            end
            wa_reg    <= wgt;
            use_a_reg <= use_inf;
            for (int r = 0; r < 4; r++)
            begin
                row_reg[r] <= vsfi_pkg::ROW_W'(prod_reg[r]) + vsfi_pkg::ROW_W'(prod_reg[4+r])
                            + vsfi_pkg::ROW_W'(prod_reg[8+r]) + vsfi_pkg::ROW_W'(prod_reg[12+r]);
            end
            wb_reg    <= wa_reg;
            use_b_reg <= use_a_reg;
            // floor(t*w/2^15) with w nonnegative is the arithmetic shift of the product.
            for (int r = 0; r < 4; r++)
            begin
                logic signed [vsfi_pkg::ROW_W+vsfi_pkg::WGT_W:0] tw;
                tw = row_reg[r] * $signed({1'b0, wb_reg});
                term_reg[r] <= use_b_reg ? vsfi_pkg::TERM_W'(tw >>> 15) : '0;
            end
        end
    end

    assign term = term_reg;

endmodule

@@ design/vertex_skinning_four_influence.sv @@
// Top level: palette storage, four influence lanes, accumulation and output register.
//
// Usage: one input stream (s_axis_*) carries both load and skin transactions;
// tuser selects them (0 = load one palette element, 1 = skin one vertex).
// A load transaction writes bone_palette[entry_bone*16 + entry_slot] and makes
// no result; a bone at or above NUM_BONES is dropped. A skin transaction makes
// one result on m_axis_* holding the skinned vec4 (x,y,z,w), saturated Q16.16.
// Throughput: one transaction per cycle while the receiver does not stall. A skin
// transaction passes the palette read, products, row sums and weighting, then
// sum/saturate into the output register, before it is valid on m_axis.
// Each lane owns 16 RAM banks (one per matrix element); a load writes the bank
// of entry_slot in every lane, every bank is read on every accepted transaction,
// so all 16 elements of a bone arrive together and the banks never limit the rate.
// The whole pipeline advances only when the output register is empty or being
// taken, so a receiver stall holds every stage; nothing is lost or repeated.
// Reset clears the valid bits; the palette is not cleared and must be loaded
// before any bone it holds is used.
module vertex_skinning_four_influence (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: pos_x, pos_y, pos_z, bone_indices, weights, entry_bone, entry_slot,
    //        entry_value (from bit 0 up), zero-filled to 240 bits
    input  logic [vsfi_pkg::TDATA_IN_W-1:0] s_axis_tdata,
    // tuser: action
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: out_x, out_y, out_z, out_w (from bit 0 up)
    output logic [vsfi_pkg::TDATA_OUT_W-1:0] m_axis_tdata
);

    logic adv;
    logic out_valid_reg;
    logic [vsfi_pkg::PIPE_STAGES-1:0] vld_reg;
    logic [vsfi_pkg::TDATA_OUT_W-1:0] out_data_reg;

    // Unpack input fields.
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic [31:0] bone_indices;
    logic [63:0] weights;
    logic [vsfi_pkg::BONE_W-1:0] entry_bone;
    logic [vsfi_pkg::SLOT_W-1:0] entry_slot;
    logic [31:0] entry_value;
    assign pos_x        = s_axis_tdata[31:0];
    assign pos_y        = s_axis_tdata[63:32];
    assign pos_z        = s_axis_tdata[95:64];
    assign bone_indices = s_axis_tdata[127:96];
    assign weights      = s_axis_tdata[191:128];
    assign entry_bone   = s_axis_tdata[197:192];
    assign entry_slot   = s_axis_tdata[201:198];
    assign entry_value  = s_axis_tdata[233:202];

    assign adv = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;

    logic acc_in, skin_in, load_in;
    assign acc_in  = s_axis_tvalid && adv;
    assign skin_in = acc_in && (s_axis_tuser == vsfi_pkg::ACT_SKIN);
    assign load_in = acc_in && (s_axis_tuser == vsfi_pkg::ACT_LOAD)
                   && (32'(entry_bone) < vsfi_pkg::NUM_BONES);

    // Stage 0 (RAM read) side info.
    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic [vsfi_pkg::WGT_W-1:0] w0_reg [4];
    logic use0_reg [4];
    logic [31:0] mrd [4][16];

    genvar g, e;
    generate
        for (g = 0; g < 4; g++)
        begin : g_inf
            logic [vsfi_pkg::IDX_W-1:0] idx;
            assign idx = bone_indices[g*8 +: 8];
            for (e = 0; e < 16; e++)
            begin : g_bank
                vsfi_ram #(.WIDTH(32), .DEPTH(vsfi_pkg::NUM_BONES)) u_ram (
                    .clk   (clk),
                    .we    (load_in && (entry_slot == vsfi_pkg::SLOT_W'(e))),
                    .waddr (entry_bone),
                    .wdata (entry_value),
                    .re    (adv),
                    .raddr (idx[vsfi_pkg::BONE_W-1:0]),
                    .rdata (mrd[g][e])
                );
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg <= pos_x;
            py_reg <= pos_y;
            pz_reg <= pos_z;
            for (int k = 0; k < 4; k++)
            begin
                w0_reg[k]   <= weights[k*16 +: 16];
                use0_reg[k] <= (weights[k*16 +: 16] != '0)
                             && (32'(bone_indices[k*8 +: 8]) < vsfi_pkg::NUM_BONES);
            end
        end
    end

    logic signed [vsfi_pkg::TERM_W-1:0] terms [4][4];
    generate
        for (g = 0; g < 4; g++)
        begin : g_lane
            vsfi_lane u_lane (
                .clk     (clk),
                .adv     (adv),
                .m       (mrd[g]),
                .px      (px_reg),
                .py      (py_reg),
                .pz      (pz_reg),
                .wgt     (w0_reg[g]),
                .use_inf (use0_reg[g]),
                .term    (terms[g])
            );
        end
    endgenerate

    // Stage: sum four influence terms per row and saturate.
    logic [vsfi_pkg::TDATA_OUT_W-1:0] out_data_next;
    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            logic signed [vsfi_pkg::ACC_W-1:0] s;
            s = vsfi_pkg::ACC_W'(terms[0][r]) + vsfi_pkg::ACC_W'(terms[1][r])
              + vsfi_pkg::ACC_W'(terms[2][r]) + vsfi_pkg::ACC_W'(terms[3][r]);
            out_data_next[r*32 +: 32] = vsfi_pkg::sat32(s);
        end
    end

    // Valid chain: RAM read, products, row sums, weighting, then output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[vsfi_pkg::PIPE_STAGES-2:0], skin_in};
            out_valid_reg <= vld_reg[vsfi_pkg::PIPE_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef SYNTH
    // Hold the result while the receiver stalls.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |=> out_valid_reg && $stable(out_data_reg))
        else $error("result changed under stall");
    // Accept input exactly when the pipeline advances.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!out_valid_reg || m_axis_tready))
        else $error("ready mismatch");
    // The last valid bit moves into the output register on an advance.
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        adv && vld_reg[vsfi_pkg::PIPE_STAGES-1] |=> out_valid_reg)
        else $error("lost result");
`endif

endmodule
